// ===== sv/sasb_pkg.sv =====
// Package for the scaled alpha sprite blitter: widths, constants and stage types.
package sasb_pkg;

   localparam int CanvasBits  = 10;           // canvas is 1024 x 1024
   localparam int TexelBits   = 18;           // 262144 sprite texels
   localparam int DivStages   = 5;            // two quotient bits per stage
   localparam int QuotBits    = 10;
   localparam int NumBits     = 21;
   localparam int DenBits     = 12;
   localparam logic [7:0]  AlphaMin   = 8'd3;
   localparam logic [7:0]  ChanMax    = 8'd255;
   localparam logic [15:0] Recip255   = 16'd32897;   // ceil(2^23 / 255)

   localparam logic REQ_LOAD  = 1'b0;
   localparam logic REQ_BLEND = 1'b1;

   localparam logic [2:0] CSR_SRC_WIDTH  = 3'd0;
   localparam logic [2:0] CSR_SRC_HEIGHT = 3'd1;
   localparam logic [2:0] CSR_DST_LEFT   = 3'd2;
   localparam logic [2:0] CSR_DST_TOP    = 3'd3;
   localparam logic [2:0] CSR_DST_WIDTH  = 3'd4;
   localparam logic [2:0] CSR_DST_HEIGHT = 3'd5;

   // Side data that rides along the pipeline with each request.
   typedef struct packed {
      logic                    valid;
      logic                    is_load;
      logic                    ok;
      logic [CanvasBits-1:0]   cx;
      logic [CanvasBits-1:0]   cy;
      logic [7:0]              red;
      logic [7:0]              green;
      logic [7:0]              blue;
      logic [TexelBits-1:0]    tidx;
      logic [31:0]             tcolor;
   } side_type;

endpackage

// ===== sv/sasb_div.sv =====
// Pipelined restoring divider: 10-bit quotient, two bits per stage.
module sasb_div (
   input  logic                          clock,
   input  logic                          enable,
   input  logic [sasb_pkg::NumBits-1:0]  num,
   input  logic [sasb_pkg::DenBits-1:0]  den,
   output logic [sasb_pkg::QuotBits-1:0] quot
);

   logic [sasb_pkg::NumBits-1:0]  rem_ff    [sasb_pkg::DivStages];
   logic [sasb_pkg::QuotBits-1:0] quot_ff   [sasb_pkg::DivStages];
   logic [sasb_pkg::NumBits-1:0]  rem_in    [sasb_pkg::DivStages];
   logic [sasb_pkg::QuotBits-1:0] quot_in   [sasb_pkg::DivStages];
   logic [sasb_pkg::NumBits-1:0]  rem_prev  [sasb_pkg::DivStages];
   logic [sasb_pkg::QuotBits-1:0] quot_prev [sasb_pkg::DivStages];

   for (genvar k = 0; k < sasb_pkg::DivStages; k++) begin : g_stage
      if (k == 0) begin : g_first
         assign rem_prev[k]  = num;
         assign quot_prev[k] = '0;
      end else begin : g_next
         assign rem_prev[k]  = rem_ff[k-1];
         assign quot_prev[k] = quot_ff[k-1];
      end

      always_comb begin
         logic [sasb_pkg::NumBits:0] r;
         logic [sasb_pkg::NumBits:0] t;
         logic [sasb_pkg::QuotBits-1:0] q;
         r = {1'b0, rem_prev[k]};
         q = quot_prev[k];
         for (int j = 0; j < 2; j++) begin
            t = {{(sasb_pkg::NumBits+1-sasb_pkg::DenBits){1'b0}}, den}
                << (sasb_pkg::QuotBits - 1 - 2*k - j);
            if (r >= t) begin
               r = r - t;
               q[sasb_pkg::QuotBits-1-2*k-j] = 1'b1;
            end
         end
         rem_in[k]  = r[sasb_pkg::NumBits-1:0];
         quot_in[k] = q;
      end

      always_ff @(posedge clock) begin
         if (enable) begin
            rem_ff[k]  <= rem_in[k];
            quot_ff[k] <= quot_in[k];
         end
      end
   end

   assign quot = quot_ff[sasb_pkg::DivStages-1];

endmodule

// ===== sv/scaled_alpha_sprite_blit.sv =====
// Top level of the scaled alpha sprite blitter.
// Takes one request per cycle while req_ready is high, load or blend, and returns at
// most one canvas write per blend, through eleven register stages: capture, numerators,
// five divider stages, texel address, memory read, channel products, output. The whole
// pipeline advances together whenever the output register is empty or being taken, so
// throughput is one request per cycle and a stalled write freezes every stage; latency
// is set mostly by the two five-stage dividers that form the nearest-neighbor source
// coordinates. Loads travel the same pipeline and write the sprite memory in the stage
// where blends read it, so requests act on the store strictly in order. Unwritten texels
// are undefined. Configuration must be written only while the pipeline is empty; the
// block itself does not enforce it.
module scaled_alpha_sprite_blit (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic        req_type,
   input  logic [17:0] req_texel_index,
   input  logic [31:0] req_texel_color,
   input  logic [9:0]  req_offset_col,
   input  logic [9:0]  req_offset_row,
   input  logic [7:0]  req_canvas_red,
   input  logic [7:0]  req_canvas_green,
   input  logic [7:0]  req_canvas_blue,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [19:0] rsp_canvas_address,
   output logic [7:0]  rsp_blend_red,
   output logic [7:0]  rsp_blend_green,
   output logic [7:0]  rsp_blend_blue,
   input  logic        csr_we,
   input  logic [2:0]  csr_index,
   input  logic [10:0] csr_data
);

   // configuration
   logic [9:0]         src_width_ff, src_height_ff;
   logic signed [10:0] dst_left_ff, dst_top_ff;
   logic [10:0]        dst_width_ff, dst_height_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         src_width_ff  <= 10'd1;
         src_height_ff <= 10'd1;
         dst_left_ff   <= '0;
         dst_top_ff    <= '0;
         dst_width_ff  <= '0;
         dst_height_ff <= '0;
      end else if (csr_we) begin
         unique case (csr_index)
            sasb_pkg::CSR_SRC_WIDTH:  src_width_ff  <= csr_data[9:0];
            sasb_pkg::CSR_SRC_HEIGHT: src_height_ff <= csr_data[9:0];
            sasb_pkg::CSR_DST_LEFT:   dst_left_ff   <= csr_data;
            sasb_pkg::CSR_DST_TOP:    dst_top_ff    <= csr_data;
            sasb_pkg::CSR_DST_WIDTH:  dst_width_ff  <= csr_data;
            sasb_pkg::CSR_DST_HEIGHT: dst_height_ff <= csr_data;
            default: ;
         endcase
      end
   end

   // one enable for every stage: move when the output slot is free or draining
   logic advance;
   logic rsp_valid_ff;
   assign advance   = !rsp_valid_ff || rsp_ready;
   assign req_ready = advance;

   // stage A: captured request
   sasb_pkg::side_type a_ff;
   logic [9:0] a_col_ff, a_row_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         a_ff.valid <= 1'b0;
      end else if (advance) begin
         a_ff.valid <= req_valid;
      end
      if (advance) begin
         a_ff.is_load <= (req_type == sasb_pkg::REQ_LOAD);
         a_ff.ok      <= 1'b0;
         a_ff.cx      <= '0;
         a_ff.cy      <= '0;
         a_ff.red     <= req_canvas_red;
         a_ff.green   <= req_canvas_green;
         a_ff.blue    <= req_canvas_blue;
         a_ff.tidx    <= req_texel_index;
         a_ff.tcolor  <= req_texel_color;
         a_col_ff     <= req_offset_col;
         a_row_ff     <= req_offset_row;
      end
   end

   // rectangle and canvas bounds, numerators (2*off+1)*src
   logic signed [11:0] cx_s, cy_s;
   logic               a_ok;
   logic [20:0]        nx_c, ny_c;
   sasb_pkg::side_type b_in;

   always_comb begin
      cx_s = 12'(dst_left_ff) + $signed({2'b00, a_col_ff});
      cy_s = 12'(dst_top_ff)  + $signed({2'b00, a_row_ff});
      a_ok = ({1'b0, a_col_ff} < dst_width_ff) && ({1'b0, a_row_ff} < dst_height_ff)
             && (src_width_ff != '0) && (src_height_ff != '0)
             && (cx_s[11:10] == 2'b00) && (cy_s[11:10] == 2'b00);
      nx_c = 21'({a_col_ff, 1'b1}) * 21'(src_width_ff);
      ny_c = 21'({a_row_ff, 1'b1}) * 21'(src_height_ff);
      b_in    = a_ff;
      b_in.ok = a_ok;
      b_in.cx = cx_s[9:0];
      b_in.cy = cy_s[9:0];
   end

   // stage B: numerators to the dividers
   sasb_pkg::side_type b_ff;
   logic [20:0]        nx_ff, ny_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         b_ff.valid <= 1'b0;
      end else if (advance) begin
         b_ff.valid <= b_in.valid;
      end
      if (advance) begin
         b_ff[$bits(sasb_pkg::side_type)-2:0] <= b_in[$bits(sasb_pkg::side_type)-2:0];
         nx_ff <= nx_c;
         ny_ff <= ny_c;
      end
   end

   logic [9:0] sx, sy;

   sasb_div u_div_x (
      .clock  (clock),
      .enable (advance),
      .num    (nx_ff),
      .den    ({dst_width_ff, 1'b0}),
      .quot   (sx)
   );

   sasb_div u_div_y (
      .clock  (clock),
      .enable (advance),
      .num    (ny_ff),
      .den    ({dst_height_ff, 1'b0}),
      .quot   (sy)
   );

   // side data delay line matching the divider depth
   sasb_pkg::side_type d_ff [sasb_pkg::DivStages];

   for (genvar k = 0; k < sasb_pkg::DivStages; k++) begin : g_side
      sasb_pkg::side_type d_prev;

      if (k == 0) begin : g_first
         assign d_prev = b_ff;
      end else begin : g_next
         assign d_prev = d_ff[k-1];
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            d_ff[k].valid <= 1'b0;
         end else if (advance) begin
            d_ff[k].valid <= d_prev.valid;
         end
         if (advance) begin
            d_ff[k][$bits(sasb_pkg::side_type)-2:0] <=
               d_prev[$bits(sasb_pkg::side_type)-2:0];
         end
      end
   end

   // stage E: texel address sy*src_width+sx
   logic [19:0]        addr_c;
   sasb_pkg::side_type e_in, e_ff;
   logic [17:0]        e_addr_ff;

   always_comb begin
      addr_c = 20'(sy) * 20'(src_width_ff) + 20'(sx);
      e_in    = d_ff[sasb_pkg::DivStages-1];
      e_in.ok = e_in.ok && (addr_c[19:18] == 2'b00);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         e_ff.valid <= 1'b0;
      end else if (advance) begin
         e_ff.valid <= e_in.valid;
      end
      if (advance) begin
         e_ff[$bits(sasb_pkg::side_type)-2:0] <= e_in[$bits(sasb_pkg::side_type)-2:0];
         e_addr_ff <= addr_c[17:0];
      end
   end

   // sprite store: loads write and blends read in the same stage, keeping order
   logic [31:0] sprite_mem [2**sasb_pkg::TexelBits];
   logic [31:0] texel_ff;
   sasb_pkg::side_type f_ff;

   always_ff @(posedge clock) begin
      if (advance) begin
         if (e_ff.valid && e_ff.is_load) begin
            sprite_mem[e_ff.tidx] <= e_ff.tcolor;
         end
         texel_ff <= sprite_mem[e_addr_ff];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         f_ff.valid <= 1'b0;
      end else if (advance) begin
         f_ff.valid <= e_ff.valid;
      end
      if (advance) begin
         f_ff[$bits(sasb_pkg::side_type)-2:0] <= e_ff[$bits(sasb_pkg::side_type)-2:0];
      end
   end

   // stage G: p*a + b*(255-a) per channel
   logic [7:0]  alpha, inv_alpha;
   logic        g_fire_in, g_fire_ff;
   logic [15:0] mr_ff, mg_ff, mb_ff;
   logic [9:0]  g_cx_ff, g_cy_ff;

   assign alpha     = texel_ff[31:24];
   assign inv_alpha = sasb_pkg::ChanMax - alpha;
   assign g_fire_in = f_ff.valid && !f_ff.is_load && f_ff.ok && (alpha >= sasb_pkg::AlphaMin);

   always_ff @(posedge clock) begin
      if (reset) begin
         g_fire_ff <= 1'b0;
      end else if (advance) begin
         g_fire_ff <= g_fire_in;
      end
      if (advance) begin
         mr_ff   <= 16'(texel_ff[7:0])   * 16'(alpha) + 16'(f_ff.red)   * 16'(inv_alpha);
         mg_ff   <= 16'(texel_ff[15:8])  * 16'(alpha) + 16'(f_ff.green) * 16'(inv_alpha);
         mb_ff   <= 16'(texel_ff[23:16]) * 16'(alpha) + 16'(f_ff.blue)  * 16'(inv_alpha);
         g_cx_ff <= f_ff.cx;
         g_cy_ff <= f_ff.cy;
      end
   end

   // output register: divide by 255 through the reciprocal
   logic [31:0] qr, qg, qb;
   logic [7:0]  red_ff, green_ff, blue_ff;
   logic [19:0] addr_ff;

   assign qr = 32'(mr_ff) * 32'(sasb_pkg::Recip255);
   assign qg = 32'(mg_ff) * 32'(sasb_pkg::Recip255);
   assign qb = 32'(mb_ff) * 32'(sasb_pkg::Recip255);

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (advance) begin
         rsp_valid_ff <= g_fire_ff;
      end
      if (advance) begin
         red_ff   <= qr[30:23];
         green_ff <= qg[30:23];
         blue_ff  <= qb[30:23];
         addr_ff  <= {g_cy_ff, g_cx_ff};
      end
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_canvas_address = addr_ff;
   assign rsp_blend_red      = red_ff;
   assign rsp_blend_green    = green_ff;
   assign rsp_blend_blue     = blue_ff;

endmodule

// ===== sv/sasb_chk.sv =====
// Port-level checker for the sprite blitter, bound to the top level.
module sasb_chk (
   input logic        clock,
   input logic        reset,
   input logic        req_ready,
   input logic        rsp_valid,
   input logic        rsp_ready,
   input logic [19:0] rsp_canvas_address,
   input logic [7:0]  rsp_blend_red
);

   a_reset_empty : assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("response valid after reset");

   a_ready_rule : assert property (@(posedge clock) disable iff (reset)
      req_ready == (!rsp_valid || rsp_ready))
      else $error("request ready does not follow output slot");

   a_rsp_hold : assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_canvas_address)
      && $stable(rsp_blend_red))
      else $error("stalled response changed");

endmodule

bind scaled_alpha_sprite_blit sasb_chk u_sasb_chk (
   .clock              (clock),
   .reset              (reset),
   .req_ready          (req_ready),
   .rsp_valid          (rsp_valid),
   .rsp_ready          (rsp_ready),
   .rsp_canvas_address (rsp_canvas_address),
   .rsp_blend_red      (rsp_blend_red)
);
